[rtl/mexp_pkg.sv]
// shared constants for the modular exponentiation block
`default_nettype none

package mexp_pkg;

  localparam int WIDTH_DEF  = 64;
  localparam int FIELD_W    = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

endpackage

`default_nettype wire

[rtl/mexp_stream_if.sv]
// valid/ready channels for base words and result words
`default_nettype none

interface mexp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FIELD_W-1:0]  base;

  modport source (output valid, output base, input ready);
  modport sink (input valid, input base, output ready);
endinterface

interface mexp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FIELD_W-1:0]  power;
  logic                          bad_modulus;

  modport source (output valid, output power, output bad_modulus, input ready);
  modport sink (input valid, input power, input bad_modulus, output ready);
endinterface

`default_nettype wire

[rtl/modular_exponentiation.sv]
// top level: right-to-left square-and-multiply modular exponentiation
// one base word at a time, worked by the two bit-serial multipliers with a doubling
// step and an add step per multiplier bit; a new base word is taken only once the
// previous result has been loaded into the output register, which waits while an
// earlier result word is stalled; a zero modulus skips the multipliers and gives a
// bad_modulus result with power 0; rst (synchronous) sets modulus 1, exponent 0
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mexp_pkg::CFG_DATA_W-1:0]   cfg_data,
  mexp_in_if.sink                           din,
  mexp_out_if.source                        dout
);

  localparam int CW = $clog2(WIDTH);
  localparam int FW = mexp_pkg::FIELD_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RED   = 5'b00010,
    S_START = 5'b00100,
    S_LOOP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state;
  logic [WIDTH-1:0]  modulus;
  logic [WIDTH-1:0]  exponent;
  logic [CW-1:0]     cnt;
  logic [WIDTH-1:0]  acc;
  logic [WIDTH-1:0]  sq;
  logic [WIDTH-1:0]  ebits;
  logic              bad;
  logic              out_valid;
  logic [WIDTH-1:0]  out_power;
  logic              out_bad;

  logic              accept;
  logic              load_out;
  logic [WIDTH-1:0]  one_mod;
  logic              start_a;
  logic              start_b;
  logic [WIDTH-1:0]  b_a;
  logic              done_a;
  logic              done_b;
  logic [WIDTH-1:0]  p_a;
  logic [WIDTH-1:0]  p_b;

  assign din.ready        = (state == S_IDLE);
  assign accept           = din.valid && din.ready;
  assign load_out         = (state == S_DONE) && (!out_valid || dout.ready);
  // 1 mod n, with a zero modulus giving 0 as well
  assign one_mod          = {{(WIDTH-1){1'b0}}, (modulus > WIDTH'(1))};
  assign start_a          = (accept && (modulus != '0)) || (state == S_START);
  assign start_b          = (state == S_START);
  // first pass through unit a reduces the base: (1 mod n) * x
  assign b_a              = (state == S_IDLE) ? din.base[WIDTH-1:0] : sq;

  assign dout.valid       = out_valid;
  assign dout.power       = FW'(out_power);
  assign dout.bad_modulus = out_bad;

  mexp_mul #(.W(WIDTH)) u_mul_a (
    .clk   (clk),
    .rst   (rst),
    .start (start_a),
    .a     (acc),
    .b     (b_a),
    .n     (modulus),
    .done  (done_a),
    .p     (p_a)
  );

  mexp_mul #(.W(WIDTH)) u_mul_b (
    .clk   (clk),
    .rst   (rst),
    .start (start_b),
    .a     (sq),
    .b     (sq),
    .n     (modulus),
    .done  (done_b),
    .p     (p_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      modulus   <= WIDTH'(1);
      exponent  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mexp_pkg::REG_MODULUS:  modulus  <= cfg_data[WIDTH-1:0];
          mexp_pkg::REG_EXPONENT: exponent <= cfg_data[WIDTH-1:0];
          default: ;
        endcase
      end
      if (dout.valid && dout.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (modulus == '0) ? S_DONE : S_RED;
          end
        end
        S_RED: begin
          if (done_a) begin
            state <= S_START;
            cnt   <= CW'(WIDTH - 1);
          end
        end
        S_START: begin
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (done_b) begin
            if (cnt == '0) begin
              state <= S_DONE;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_START;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= one_mod;
      bad <= (modulus == '0);
    end
    if ((state == S_RED) && done_a) begin
      sq    <= p_a;
      ebits <= exponent;
    end
    // both units finish together; multiply result kept only for a one bit
    if ((state == S_LOOP) && done_b) begin
      if (ebits[0]) begin
        acc <= p_a;
      end
      sq    <= p_b;
      ebits <= {1'b0, ebits[WIDTH-1:1]};
    end
    if (load_out) begin
      out_power <= acc;
      out_bad   <= bad;
    end
  end

endmodule

`default_nettype wire

[rtl/mexp_mul.sv]
// bit-serial modular multiplier, shift-and-add over the multiplier bits msb first
`default_nettype none

module mexp_mul #(
  parameter int W = mexp_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] p
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic          phase;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  bsh;
  logic [W-1:0]  addend;
  logic [W-1:0]  sum;

  // (x + y) mod m for x, y below m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  // phase 0 doubles the accumulator, phase 1 adds a when the bit is set
  assign addend = phase ? a : acc;
  assign sum    = add_mod(acc, addend, n);
  assign p      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CW'(W - 1);
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= '0;
      bsh <= b;
    end else if (busy) begin
      if (!phase) begin
        acc <= sum;
      end else begin
        if (bsh[W-1]) begin
          acc <= sum;
        end
        bsh <= {bsh[W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mexp_check.sv]
// port-level checks for the modular exponentiation block, bound to the top level
`default_nettype none

module mexp_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mexp_pkg::FIELD_W-1:0]  power,
  input wire logic                          bad_modulus
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power) && $stable(bad_modulus))
    else $error("result word changed while stalled");

  // an error result always carries a zero power
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_modulus |-> power == '0)
    else $error("bad modulus with nonzero power");

  // one word in flight: taking a base closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a word was taken");

  // a new result only appears after the input has been closed
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind modular_exponentiation mexp_check u_mexp_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .power       (dout.power),
  .bad_modulus (dout.bad_modulus)
);

`default_nettype wire

[sim/modular_exponentiation_tb.sv]
// self-checking testbench for the modular exponentiation block
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int WIDTH = WIDTH_DEF;
  localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WIDTH);
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam int LATENCY = 2 * WIDTH * WIDTH + 4 * WIDTH + 2;
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [63:0] power;
    logic        bad_modulus;
  } result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mexp_in_if  din_ch ();
  mexp_out_if dout_ch ();

  modular_exponentiation #(.WIDTH(WIDTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  // key held by the predictor, mirrors the block's registers
  logic [63:0] key_modulus;
  logic [63:0] key_exponent;

  result_t     pending_results[$];
  result_t     want;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  int          mismatch_count;
  int          bases_sent;
  int          results_checked;
  int          keys_loaded;
  int          bad_modulus_seen;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, n});
  endfunction

  function automatic result_t expected_power(input logic [63:0] base_in);
    logic [63:0] n, k, acc, sq;
    result_t     r;
    n = key_modulus & WORD_MASK;
    k = key_exponent & WORD_MASK;
    if (n == 64'd0) begin
      r.power = 64'd0;
      r.bad_modulus = 1'b1;
      return r;
    end
    acc = 64'd1 % n;
    sq = (base_in & WORD_MASK) % n;
    // right-to-left: multiply in the running square on each one bit
    for (int i = 0; i < WIDTH; i++) begin
      if (k[i]) acc = mul_mod(acc, sq, n);
      sq = mul_mod(sq, sq, n);
    end
    r.power = acc & WORD_MASK;
    r.bad_modulus = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // receiver side
  always @(negedge clk) begin
    dout_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && dout_ch.valid && dout_ch.ready) begin
      results_checked++;
      if (dout_ch.bad_modulus === 1'b1) bad_modulus_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: power %h bad_modulus %b",
                   dout_ch.power, dout_ch.bad_modulus);
      end else begin
        want = pending_results.pop_front();
        if (dout_ch.power !== want.power || dout_ch.bad_modulus !== want.bad_modulus) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: power exp %h got %h, bad_modulus exp %b got %b",
                     want.power, dout_ch.power, want.bad_modulus, dout_ch.bad_modulus);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_base(input logic [63:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      din_ch.valid <= 1'b0;
      @(negedge clk);
    end
    din_ch.valid <= 1'b1;
    din_ch.base <= value;
    do @(posedge clk); while (din_ch.ready !== 1'b1);
    pending_results.push_back(expected_power(value));
    bases_sent++;
  endtask

  // stop sending and wait for every outstanding word
  task automatic drain();
    @(negedge clk);
    din_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS:  key_modulus = value;
      REG_EXPONENT: key_exponent = value;
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [63:0] n, input logic [63:0] k);
    drain();
    write_register(REG_MODULUS, n);
    write_register(REG_EXPONENT, k);
    keys_loaded++;
  endtask

  // reset key is modulus one, exponent zero
  task automatic test_reset_state();
    send_base(64'd0);
    send_base(ALL_ONES);
  endtask

  task automatic test_zero_modulus();
    load_key(64'd0, rand_word());
    send_base(64'd0);
    send_base(ALL_ONES);
    send_base(rand_word());
  endtask

  task automatic test_zero_exponent();
    load_key(ALL_ONES, 64'd0);
    send_base(64'd0);
    send_base(ALL_ONES);
    send_base(64'd5);
    load_key(64'd1, ALL_ONES);
    send_base(ALL_ONES);
  endtask

  task automatic test_extreme_operands();
    load_key(ALL_ONES, ALL_ONES);
    send_base(64'd0);
    send_base(64'd1);
    send_base(ALL_ONES);
    send_base(ALL_ONES - 64'd1);
    send_base(64'd2);
    load_key(64'h8000_0000_0000_0000, 64'd3);
    send_base(ALL_ONES);
    send_base(64'd3);
    // only the top exponent bit set
    load_key(rand_word() | 64'd1, 64'h8000_0000_0000_0000);
    send_base(64'd3);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n_items);
    logic [63:0] n, k, b;
    int          left;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        0: n = 64'd0;
        1: n = 64'd1;
        2: n = ALL_ONES;
        3: n = 64'd2;
        4: n = 64'($urandom_range(255, 3));
        default: n = rand_word();
      endcase
      case ($urandom_range(5))
        0: k = 64'd0;
        1: k = 64'd1;
        2: k = ALL_ONES;
        3: k = 64'($urandom_range(65535));
        default: k = rand_word();
      endcase
      load_key(n, k);
      for (int i = 0; i < 6 && left > 0; i++) begin
        case ($urandom_range(7))
          0: b = 64'd0;
          1: b = ALL_ONES;
          2: b = n;
          3: b = n - 64'd1;
          default: b = rand_word();
        endcase
        send_base(b);
        left--;
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_data = 64'd0;
    din_ch.valid = 1'b0;
    din_ch.base = 64'd0;
    dout_ch.ready = 1'b0;
    key_modulus = 64'd1;
    key_exponent = 64'd0;
    send_idle_pct = 26;
    recv_idle_pct = 71;
    cycle_count = 0;
    mismatch_count = 0;
    bases_sent = 0;
    results_checked = 0;
    keys_loaded = 0;
    bad_modulus_seen = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_zero_modulus();
    test_zero_exponent();
    test_extreme_operands();
    test_random_traffic(26, 71, 33);
    test_random_traffic(71, 26, 33);
    test_random_traffic(0, 0, 34);

    // catch any stray word after the last expected one
    repeat (LATENCY) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;

    $display("%0d bases sent under %0d keys, %0d results checked (%0d with bad modulus)",
             bases_sent, keys_loaded, results_checked, bad_modulus_seen);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mexp_pkg.sv
rtl/mexp_stream_if.sv
rtl/mexp_mul.sv
rtl/modular_exponentiation.sv
rtl/mexp_check.sv
sim/modular_exponentiation_tb.sv
